/* rtl/core/kned_pkg.sv */
package kned_pkg;

  localparam logic [7:0] CharEsc   = 8'h5F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CaseBit   = 8'h20;
  localparam logic [7:0] OctalHigh = 8'h37;

  // Character class worked out by the front end.
  typedef enum logic [2:0] {
    CLS_END,
    CLS_DIGIT,
    CLS_UPPER,
    CLS_ESC,
    CLS_OTHER
  } char_cls_e;

  // Position inside an escape sequence.
  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_ESC,
    PH_OCT1,
    PH_OCT2
  } esc_phase_e;

  typedef struct packed {
    char_cls_e  cls;
    logic       octal;
    logic [7:0] ch;
  } char_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    is_upper = (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    is_lower = (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    is_octal = (c >= 8'h30) && (c <= OctalHigh);
  endfunction

endpackage

/* rtl/core/key_name_escape_decoder.sv */
// Each accepted word is written into the character queue and then loaded into the
// output register; the back end waits while the output holds a word not yet taken.
// Throughput: one word per cycle while the output side accepts words.
// The queue holds QueueDepth classified characters, so either side may stall on its own.
// Reset (rst_ni low, asynchronous) empties the queue and the output register and
// returns the decoder to the start of a name.
module key_name_escape_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_value_o,
  output logic       name_done_o,
  output logic       name_ok_o
);
  import kned_pkg::*;

  char_item_t front_item, queue_item;
  logic       push, q_ready, q_valid, pop;

  kned_front u_front (
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .q_ready_i  (q_ready),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .item_o     (front_item)
  );

  kned_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (queue_item)
  );

  kned_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_valid_o (byte_valid_o),
    .byte_value_o (byte_value_o),
    .name_done_o  (name_done_o),
    .name_ok_o    (name_ok_o)
  );

endmodule

/* rtl/core/kned_front.sv */
module kned_front (
  input  logic                in_valid_i,
  input  logic [7:0]          char_in_i,
  input  logic                q_ready_i,
  output logic                in_ready_o,
  output logic                push_o,
  output kned_pkg::char_item_t item_o
);
  import kned_pkg::*;

  char_cls_e cls_c;

  always_comb begin
    if (char_in_i == 8'h00) begin
      cls_c = CLS_END;
    end else if (is_digit(char_in_i)) begin
      cls_c = CLS_DIGIT;
    end else if (is_upper(char_in_i)) begin
      cls_c = CLS_UPPER;
    end else if (char_in_i == CharEsc) begin
      cls_c = CLS_ESC;
    end else begin
      cls_c = CLS_OTHER;
    end
  end

  assign item_o.cls   = cls_c;
  assign item_o.octal = is_octal(char_in_i);
  assign item_o.ch    = char_in_i;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule

/* rtl/core/kned_queue.sv */
module kned_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kned_pkg::char_item_t push_item_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output kned_pkg::char_item_t pop_item_o
);
  import kned_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  char_item_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o    = (cnt_q != FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/core/kned_back.sv */
module kned_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  kned_pkg::char_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 byte_valid_o,
  output logic [7:0]           byte_value_o,
  output logic                 name_done_o,
  output logic                 name_ok_o
);
  import kned_pkg::*;

  esc_phase_e phase_q, phase_d;
  logic [5:0] partial_q, partial_d;
  logic       seen_q, seen_d;
  logic       err_q, err_d;
  logic       out_valid_q;
  logic       bvalid_q, done_q, ok_q;
  logic [7:0] bvalue_q;

  logic       emit_c, bad_c, done_c, ok_c;
  logic [7:0] value_c;
  logic [8:0] oct_val;
  logic       oct_reject;
  logic       take;

  assign take  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = take;

  // Full three-digit octal value and the bytes an escape may not stand for.
  assign oct_val    = {partial_q, item_i.ch[2:0]};
  assign oct_reject = (oct_val == 9'd0) || oct_val[8] || is_digit(oct_val[7:0])
                      || is_upper(oct_val[7:0]) || is_lower(oct_val[7:0])
                      || (oct_val[7:0] == CharDot);

  // Result of the current word and whether it breaks the name.
  always_comb begin
    emit_c  = 1'b0;
    bad_c   = 1'b0;
    value_c = 8'h00;
    done_c  = 1'b0;
    ok_c    = 1'b0;
    if (item_i.cls == CLS_END) begin
      done_c = 1'b1;
      ok_c   = seen_q && !err_q && (phase_q == PH_PLAIN);
    end else if (!err_q) begin
      case (phase_q)
        PH_PLAIN: begin
          if (item_i.cls == CLS_DIGIT) begin
            emit_c  = 1'b1;
            value_c = item_i.ch;
          end else if (item_i.cls == CLS_UPPER) begin
            emit_c  = 1'b1;
            value_c = item_i.ch | CaseBit;
          end else if (item_i.cls != CLS_ESC) begin
            bad_c = 1'b1;
          end
        end
        PH_ESC: begin
          if (item_i.cls == CLS_ESC) begin
            emit_c  = 1'b1;
            value_c = CharDot;
          end else if (item_i.cls == CLS_UPPER) begin
            emit_c  = 1'b1;
            value_c = item_i.ch;
          end else if (!item_i.octal) begin
            bad_c = 1'b1;
          end
        end
        PH_OCT1: begin
          bad_c = !item_i.octal;
        end
        PH_OCT2: begin
          if (item_i.octal && !oct_reject) begin
            emit_c  = 1'b1;
            value_c = oct_val[7:0];
          end else begin
            bad_c = 1'b1;
          end
        end
        default: begin
          bad_c = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    seen_d    = seen_q;
    err_d     = err_q;
    if (item_i.cls == CLS_END) begin
      phase_d   = PH_PLAIN;
      partial_d = '0;
      seen_d    = 1'b0;
      err_d     = 1'b0;
    end else begin
      seen_d = 1'b1;
      if (!err_q) begin
        case (phase_q)
          PH_PLAIN: begin
            if (item_i.cls == CLS_ESC) begin
              phase_d = PH_ESC;
            end
          end
          PH_ESC: begin
            if (item_i.octal) begin
              partial_d = {3'b000, item_i.ch[2:0]};
              phase_d   = PH_OCT1;
            end
          end
          PH_OCT1: begin
            partial_d = {partial_q[2:0], item_i.ch[2:0]};
            phase_d   = PH_OCT2;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        if (bad_c || emit_c) begin
          phase_d   = PH_PLAIN;
          partial_d = '0;
        end
        err_d = bad_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PLAIN;
      partial_q   <= '0;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        partial_q <= partial_d;
        seen_q    <= seen_d;
        err_q     <= err_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bvalid_q <= emit_c;
      bvalue_q <= value_c;
      done_q   <= done_c;
      ok_q     <= ok_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = bvalid_q;
  assign byte_value_o = bvalue_q;
  assign name_done_o  = done_q;
  assign name_ok_o    = ok_q;

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kned_pkg::*;

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharCapA = 8'h41;
  localparam logic [7:0] CharCapZ = 8'h5A;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowZ = 8'h7A;
  localparam logic [8:0] ByteMax  = 9'h0FF;

  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned QuietTail   = 300;
  localparam int unsigned TargetChars = 1700;

  // Kinds of token in a generated name.
  typedef enum int {
    TOK_DIGIT,
    TOK_UPPER,
    TOK_DOT,
    TOK_ESC_UPPER,
    TOK_OCTAL,
    TOK_BAD_PLAIN,
    TOK_BAD_ESC,
    TOK_BAD_OCTAL_CUT,
    TOK_ANY_OCTAL
  } token_kind_e;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       name_done;
    logic       name_ok;
  } decode_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_in_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       byte_valid_o;
  logic [7:0] byte_value_o;
  logic       name_done_o;
  logic       name_ok_o;

  logic [7:0]     pending_chars[$];
  decode_result_t expected_decodes[$];

  // Decoder state mirrored by the predictor.
  esc_phase_e dec_phase   = PH_PLAIN;
  logic [5:0] dec_octal   = '0;
  logic       dec_started = 1'b0;
  logic       dec_bad     = 1'b0;

  int unsigned fail_count    = 0;
  int unsigned checked_count = 0;
  int unsigned in_gap        = 0;
  int unsigned out_gap       = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;

  key_name_escape_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .byte_valid_o(byte_valid_o),
    .byte_value_o(byte_value_o),
    .name_done_o (name_done_o),
    .name_ok_o   (name_ok_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic in_span(input logic [8:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
    in_span = (c >= {1'b0, lo}) && (c <= {1'b0, hi});
  endfunction

  // Works out what one character does to the name being decoded.
  function automatic decode_result_t decode_char(input logic [7:0] c);
    decode_result_t r;
    logic [8:0]     cw;
    logic [8:0]     v;
    r  = '0;
    cw = {1'b0, c};
    v  = {dec_octal, c[2:0]};
    if (c == CharNul) begin
      r.name_done = 1'b1;
      r.name_ok   = dec_started && !dec_bad && (dec_phase == PH_PLAIN);
      dec_phase   = PH_PLAIN;
      dec_octal   = '0;
      dec_started = 1'b0;
      dec_bad     = 1'b0;
    end else begin
      dec_started = 1'b1;
      if (!dec_bad) begin
        case (dec_phase)
          PH_PLAIN: begin
            if (in_span(cw, CharZero, CharNine)) begin
              r.byte_valid = 1'b1;
              r.byte_value = c;
            end else if (in_span(cw, CharCapA, CharCapZ)) begin
              r.byte_valid = 1'b1;
              r.byte_value = c | CaseBit;
            end else if (c == CharEsc) begin
              dec_phase = PH_ESC;
            end else begin
              dec_bad = 1'b1;
            end
          end
          PH_ESC: begin
            if (c == CharEsc) begin
              r.byte_valid = 1'b1;
              r.byte_value = CharDot;
            end else if (in_span(cw, CharCapA, CharCapZ)) begin
              r.byte_valid = 1'b1;
              r.byte_value = c;
            end else if (in_span(cw, CharZero, OctalHigh)) begin
              dec_octal = {3'b000, c[2:0]};
              dec_phase = PH_OCT1;
            end else begin
              dec_bad = 1'b1;
            end
          end
          PH_OCT1: begin
            if (in_span(cw, CharZero, OctalHigh)) begin
              dec_octal = {dec_octal[2:0], c[2:0]};
              dec_phase = PH_OCT2;
            end else begin
              dec_bad = 1'b1;
            end
          end
          default: begin
            if (!in_span(cw, CharZero, OctalHigh) || v == '0 || v > ByteMax
                || in_span(v, CharCapA, CharCapZ) || in_span(v, CharLowA, CharLowZ)
                || in_span(v, CharZero, CharNine) || v == {1'b0, CharDot}) begin
              dec_bad = 1'b1;
            end else begin
              r.byte_valid = 1'b1;
              r.byte_value = v[7:0];
            end
          end
        endcase
        if (dec_bad || r.byte_valid) begin
          dec_phase = PH_PLAIN;
          dec_octal = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic void push_octal(input logic [8:0] v);
    pending_chars.push_back(CharZero | {5'b0, v[8:6]});
    pending_chars.push_back(CharZero | {5'b0, v[5:3]});
    pending_chars.push_back(CharZero | {5'b0, v[2:0]});
  endfunction

  function automatic void push_token(input token_kind_e kind);
    logic [8:0] v;
    case (kind)
      TOK_DIGIT: pending_chars.push_back(8'($urandom_range(CharZero, CharNine)));
      TOK_UPPER: pending_chars.push_back(8'($urandom_range(CharCapA, CharCapZ)));
      TOK_DOT: begin
        pending_chars.push_back(CharEsc);
        pending_chars.push_back(CharEsc);
      end
      TOK_ESC_UPPER: begin
        pending_chars.push_back(CharEsc);
        pending_chars.push_back(8'($urandom_range(CharCapA, CharCapZ)));
      end
      TOK_OCTAL: begin
        // Draw until the byte is one that the escape is allowed to carry.
        do begin
          v = 9'($urandom_range(1, 255));
        end while (in_span(v, CharCapA, CharCapZ) || in_span(v, CharLowA, CharLowZ)
                   || in_span(v, CharZero, CharNine) || v == {1'b0, CharDot});
        pending_chars.push_back(CharEsc);
        push_octal(v);
      end
      TOK_BAD_PLAIN: pending_chars.push_back(8'($urandom_range(1, 255)));
      TOK_BAD_ESC: begin
        pending_chars.push_back(CharEsc);
        pending_chars.push_back(8'($urandom_range(1, 255)));
      end
      TOK_BAD_OCTAL_CUT: begin
        pending_chars.push_back(CharEsc);
        pending_chars.push_back(8'($urandom_range(CharZero, OctalHigh)));
        if ($urandom_range(0, 1) == 1) begin
          pending_chars.push_back(8'($urandom_range(CharZero, OctalHigh)));
        end
        pending_chars.push_back(8'($urandom_range(1, 255)));
      end
      default: begin
        pending_chars.push_back(CharEsc);
        push_octal(9'($urandom_range(0, 511)));
      end
    endcase
  endfunction

  // Sender: offers the next character, holding it steady until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_decodes.push_back(decode_char(char_in_i));
      end
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        char_in_i  <= pending_chars.pop_front();
      end
    end
  end

  // Receiver: checks each word against the oldest prediction and throttles ready.
  always @(posedge clk_i) begin
    decode_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_decodes.size() == 0) begin
          fail_count++;
          $display("%t: unexpected word byte_valid=%b byte_value=%h name_done=%b name_ok=%b",
                   $realtime, byte_valid_o, byte_value_o, name_done_o, name_ok_o);
        end else begin
          want = expected_decodes.pop_front();
          checked_count++;
          if (byte_valid_o !== want.byte_valid) begin
            fail_count++;
            $display("%t: byte_valid expected %b actual %b", $realtime,
                     want.byte_valid, byte_valid_o);
          end
          if (byte_value_o !== want.byte_value) begin
            fail_count++;
            $display("%t: byte_value expected %h actual %h", $realtime,
                     want.byte_value, byte_value_o);
          end
          if (name_done_o !== want.name_done) begin
            fail_count++;
            $display("%t: name_done expected %b actual %b", $realtime,
                     want.name_done, name_done_o);
          end
          if (name_ok_o !== want.name_ok) begin
            fail_count++;
            $display("%t: name_ok expected %b actual %b", $realtime,
                     want.name_ok, name_ok_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && checked_count >= HoldAfter) begin
        // One long stall so that the queue fills and the input side backs up.
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (pending_chars.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned tokens;
    int unsigned spoil_at;
    int unsigned roll;
    logic [7:0]  directed[$];

    // Empty name; digits, capitals, escaped capital and dot; the largest octal
    // byte; an octal dot that is rejected; a name that ends inside an escape;
    // a stray high byte followed by an escape that must be ignored.
    directed = '{CharNul,
                 CharZero, CharNine, CharCapA, CharCapZ, CharEsc, CharEsc, CharEsc, CharCapA,
                 CharNul,
                 CharEsc, 8'h33, 8'h37, 8'h37, CharNul,
                 CharEsc, 8'h30, 8'h35, 8'h36, CharNul,
                 CharEsc, 8'h31, 8'h32, CharNul,
                 8'hFF, CharEsc, CharEsc, CharNul};
    pending_chars = directed;

    while (pending_chars.size() < TargetChars) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        pending_chars.push_back(CharNul);
      end else begin
        tokens   = $urandom_range(1, 8);
        spoil_at = (roll < 30) ? $urandom_range(0, tokens - 1) : tokens;
        for (int unsigned t = 0; t < tokens; t++) begin
          if (t == spoil_at) begin
            push_token(token_kind_e'($urandom_range(TOK_BAD_PLAIN, TOK_ANY_OCTAL)));
          end else begin
            push_token(token_kind_e'($urandom_range(TOK_DIGIT, TOK_OCTAL)));
          end
        end
        // Now and then the name stops part way through an escape.
        if (roll >= 30 && roll < 34) begin
          pending_chars.push_back(CharEsc);
          repeat ($urandom_range(0, 2)) begin
            pending_chars.push_back(8'($urandom_range(CharZero, OctalHigh)));
          end
        end
        pending_chars.push_back(CharNul);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && expected_decodes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%t: timed out with %0d words outstanding", $realtime,
             expected_decodes.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
